// File: rtl/bmm_pkg.sv
`timescale 1ns / 1ps

package bmm_pkg;

    // Port widths fixed by the interface.
    localparam int VIDX_W = 6;
    localparam int CNT_W  = 7;
    localparam int ACT_W  = 2;

    // Request action codes.
    localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd1;
    localparam logic [ACT_W-1:0] ACT_RUN   = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic wr_rd;
        logic wr_wr;
        logic clr_adj;
        logic run_init;
        logic try_init;
        logic scan_hit;
        logic pop_rd;
        logic pop_ld;
        logic take;
        logic push;
        logic aug_rd;
        logic aug_wr;
        logic try_done;
        logic try_ok;
        logic emit_rd;
        logic emit_ld;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hit;
        logic depth_one;
        logic depth_full;
        logic part_valid;
        logic aug_last;
        logic u_last;
        logic emit_last;
        logic out_busy;
    } stat_t;

endpackage

// File: rtl/bipartite_max_matching_top.sv
`timescale 1ns / 1ps

// Channel   | Direction | Handshake            | Payload
// ----------+-----------+----------------------+---------------------------------------------
// request   | in        | in_valid / in_stall  | action, left_vertex, right_vertex_in,
//           |           |                      | edge_present
// result    | out       | out_valid / out_stall| right_vertex_out, partner, partner_valid,
//           |           |                      | match_count, last
// config    | in        | cfg_wr_en            | cfg_wr_data (vertex_count)
//
// An edge write request reads the row, then writes it back; a clear request acts on acceptance.
// A run request is accepted, then for each left vertex it starts a try and probes right
// vertices: a probe leads one level deeper or ends on a free vertex or a full stack. It
// backtracks, gives up when nothing is left, and walks the augmenting path back; then it
// emits one result per right vertex, pausing while the receiver stalls.
// Single-ported memories: each probe waits on a partner read, each level change on a row read.
// Reset clears the edge store and the partner table at once through per-row valid bits.
// Only one request is in flight: in_stall is high from the request's acceptance until its
// last result has been loaded into the output register.
// A stalled result holds the output register and pauses the emit sequence in place.

module bipartite_max_matching_top #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [bmm_pkg::CNT_W-1:0]    cfg_wr_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [bmm_pkg::ACT_W-1:0]    action,
    input  logic [bmm_pkg::VIDX_W-1:0]   left_vertex,
    input  logic [bmm_pkg::VIDX_W-1:0]   right_vertex_in,
    input  logic                         edge_present,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [bmm_pkg::VIDX_W-1:0]   right_vertex_out,
    output logic [bmm_pkg::VIDX_W-1:0]   partner,
    output logic                         partner_valid,
    output logic [bmm_pkg::CNT_W-1:0]    match_count,
    output logic                         last
);
    import bmm_pkg::*;

    // The vertex count register; the user must write it only while no request is in flight (not enforced).
    logic [CNT_W-1:0] vertex_count_reg;

    cmd_t  cmd;
    stat_t stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vertex_count_reg <= CNT_W'(1);
        else if (cfg_wr_en)
            vertex_count_reg <= cfg_wr_data;
    end

    // The controller sequences the search; the datapath holds the memories and counters.
    bmm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .action   (action),
        .stat     (stat),
        .cmd      (cmd)
    );

    bmm_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .vertex_count     (vertex_count_reg),
        .left_vertex      (left_vertex),
        .right_vertex_in  (right_vertex_in),
        .edge_present     (edge_present),
        .out_stall        (out_stall),
        .out_valid        (out_valid),
        .right_vertex_out (right_vertex_out),
        .partner          (partner),
        .partner_valid    (partner_valid),
        .match_count      (match_count),
        .last             (last)
    );

    // The controller never issues two datapath operations that touch the same unit at once.
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.wr_rd, cmd.wr_wr, cmd.clr_adj, cmd.run_init, cmd.try_init,
                  cmd.scan_hit, cmd.pop_rd, cmd.pop_ld, cmd.take, cmd.push,
                  cmd.aug_rd, cmd.aug_wr, cmd.emit_rd, cmd.emit_ld}))
        else $error("conflicting datapath commands");

    // A new result only appears while a run holds off further requests.
    a_result_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result produced outside a run");

    // Once the final result of a run is taken, nothing follows in the next cycle.
    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && last |=> !out_valid)
        else $error("result follows the final one of a run");

endmodule

// File: rtl/bmm_ctrl.sv
`timescale 1ns / 1ps

module bmm_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [bmm_pkg::ACT_W-1:0]   action,
    input  bmm_pkg::stat_t              stat,
    output bmm_pkg::cmd_t               cmd
);
    import bmm_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_WR      = 4'd1;
    localparam logic [3:0] S_TRY     = 4'd2;
    localparam logic [3:0] S_SCAN_W  = 4'd3;
    localparam logic [3:0] S_SCAN    = 4'd4;
    localparam logic [3:0] S_PART_W  = 4'd5;
    localparam logic [3:0] S_CHECK   = 4'd6;
    localparam logic [3:0] S_POP_W   = 4'd7;
    localparam logic [3:0] S_AUG_RD  = 4'd8;
    localparam logic [3:0] S_AUG_W   = 4'd9;
    localparam logic [3:0] S_AUG_WR  = 4'd10;
    localparam logic [3:0] S_EMIT_RD = 4'd11;
    localparam logic [3:0] S_EMIT_W  = 4'd12;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (action)
                        ACT_WRITE:
                        begin
                            cmd.wr_rd  = 1'b1;
                            state_next = S_WR;
                        end
                        ACT_CLEAR: cmd.clr_adj = 1'b1;
                        ACT_RUN:
                        begin
                            cmd.run_init = 1'b1;
                            state_next   = S_TRY;
                        end
                        default: ;
                    endcase
                end
            end
            S_WR:
            begin
                cmd.wr_wr  = 1'b1;
                state_next = S_IDLE;
            end
            S_TRY:
            begin
                cmd.try_init = 1'b1;
                state_next   = S_SCAN_W;
            end
            S_SCAN_W: state_next = S_SCAN;
            S_SCAN:
            begin
                if (stat.hit)
                begin
                    cmd.scan_hit = 1'b1;
                    state_next   = S_PART_W;
                end
                else if (stat.depth_one)
                begin
                    cmd.try_done = 1'b1;
                    state_next   = stat.u_last ? S_EMIT_RD : S_TRY;
                end
                else
                begin
                    cmd.pop_rd = 1'b1;
                    state_next = S_POP_W;
                end
            end
            S_POP_W:
            begin
                cmd.pop_ld = 1'b1;
                state_next = S_SCAN_W;
            end
            S_PART_W: state_next = S_CHECK;
            S_CHECK:
            begin
                if (!stat.part_valid)
                begin
                    cmd.take = 1'b1;
                    if (stat.depth_one)
                    begin
                        cmd.try_done = 1'b1;
                        cmd.try_ok   = 1'b1;
                        state_next   = stat.u_last ? S_EMIT_RD : S_TRY;
                    end
                    else
                    begin
                        state_next = S_AUG_RD;
                    end
                end
                else if (stat.depth_full)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    cmd.push   = 1'b1;
                    state_next = S_SCAN_W;
                end
            end
            S_AUG_RD:
            begin
                cmd.aug_rd = 1'b1;
                state_next = S_AUG_W;
            end
            S_AUG_W: state_next = S_AUG_WR;
            S_AUG_WR:
            begin
                cmd.aug_wr = 1'b1;
                if (stat.aug_last)
                begin
                    cmd.try_done = 1'b1;
                    cmd.try_ok   = 1'b1;
                    state_next   = stat.u_last ? S_EMIT_RD : S_TRY;
                end
                else
                begin
                    state_next = S_AUG_RD;
                end
            end
            S_EMIT_RD:
            begin
                cmd.emit_rd = 1'b1;
                state_next  = S_EMIT_W;
            end
            S_EMIT_W:
            begin
                if (!stat.out_busy)
                begin
                    cmd.emit_ld = 1'b1;
                    state_next  = stat.emit_last ? S_IDLE : S_EMIT_RD;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// File: rtl/bmm_datapath.sv
`timescale 1ns / 1ps

module bmm_datapath #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  bmm_pkg::cmd_t                cmd,
    output bmm_pkg::stat_t               stat,
    input  logic [bmm_pkg::CNT_W-1:0]    vertex_count,
    input  logic [bmm_pkg::VIDX_W-1:0]   left_vertex,
    input  logic [bmm_pkg::VIDX_W-1:0]   right_vertex_in,
    input  logic                         edge_present,
    input  logic                         out_stall,
    output logic                         out_valid,
    output logic [bmm_pkg::VIDX_W-1:0]   right_vertex_out,
    output logic [bmm_pkg::VIDX_W-1:0]   partner,
    output logic                         partner_valid,
    output logic [bmm_pkg::CNT_W-1:0]    match_count,
    output logic                         last
);
    import bmm_pkg::*;

    localparam int IW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);

    // Adjacency rows, one row per left vertex; a row without its valid bit reads as empty.
    logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] adj_rv_reg;
    logic [MAX_VERTICES-1:0] adj_rd_reg;
    logic                    adj_rdv_reg;
    logic [MAX_VERTICES-1:0] adj_row;

    // Partner of each right vertex.
    logic [IW-1:0]           part_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] part_v_reg;
    logic [IW-1:0]           part_rd_reg;
    logic                    part_rdv_reg;

    // Search stack frames below the top frame.
    logic [IW-1:0] stk_left_mem [MAX_VERTICES];
    logic [CW-1:0] stk_next_mem [MAX_VERTICES];
    logic [IW-1:0] stk_left_rd_reg;
    logic [CW-1:0] stk_next_rd_reg;

    logic [VIDX_W-1:0]       wr_lv_reg;
    logic [VIDX_W-1:0]       wr_rv_reg;
    logic                    wr_ep_reg;
    logic [CW-1:0]           n_reg;
    logic [CW-1:0]           u_reg;
    logic [CW-1:0]           depth_reg;
    logic [CW-1:0]           aug_i_reg;
    logic [IW-1:0]           cur_left_reg;
    logic [CW-1:0]           cur_next_reg;
    logic [IW-1:0]           hit_v_reg;
    logic [MAX_VERTICES-1:0] visited_reg;
    logic [CW-1:0]           found_reg;
    logic [CW-1:0]           e_reg;

    logic [VIDX_W-1:0] out_rv_reg;
    logic [VIDX_W-1:0] out_part_reg;
    logic              out_pv_reg;
    logic [CNT_W-1:0]  out_cnt_reg;
    logic              out_last_reg;
    logic              out_valid_reg;

    logic [MAX_VERTICES-1:0] cand;
    logic [IW-1:0]           hit_idx;
    logic [CW-1:0]           n_next;

    logic                    adj_re;
    logic [IW-1:0]           adj_raddr;
    logic                    adj_we;
    logic [IW-1:0]           adj_waddr;
    logic [MAX_VERTICES-1:0] adj_wdata;

    logic          part_re;
    logic [IW-1:0] part_raddr;
    logic          part_we;
    logic [IW-1:0] part_waddr;
    logic [IW-1:0] part_wdata;

    logic          stk_re;
    logic [IW-1:0] stk_raddr;
    logic [IW-1:0] stk_waddr;

    assign adj_row = adj_rdv_reg ? adj_rd_reg : '0;

    // Candidate right vertices: an edge, not yet visited, inside [next, n).
    always_comb
    begin
        for (int k = 0; k < MAX_VERTICES; k++)
        begin
            cand[k] = adj_row[k] && !visited_reg[k]
                      && (CW'(k) >= cur_next_reg) && (CW'(k) < n_reg);
        end
    end

    always_comb
    begin
        hit_idx = '0;
        for (int k = MAX_VERTICES - 1; k >= 0; k--)
        begin
            if (cand[k])
                hit_idx = IW'(k);
        end
    end

    // A vertex count of zero runs as one, and anything above the capacity runs at capacity.
    always_comb
    begin
        if (vertex_count == '0)
            n_next = CW'(1);
        else if (int'(vertex_count) > MAX_VERTICES)
            n_next = CW'(MAX_VERTICES);
        else
            n_next = CW'(vertex_count);
    end

    always_comb
    begin
        adj_re    = 1'b0;
        adj_raddr = '0;
        if (cmd.wr_rd)
        begin
            adj_re    = 1'b1;
            adj_raddr = IW'(left_vertex);
        end
        else if (cmd.try_init)
        begin
            adj_re    = 1'b1;
            adj_raddr = IW'(u_reg);
        end
        else if (cmd.pop_ld)
        begin
            adj_re    = 1'b1;
            adj_raddr = stk_left_rd_reg;
        end
        else if (cmd.push)
        begin
            adj_re    = 1'b1;
            adj_raddr = part_rd_reg;
        end

        adj_we    = cmd.wr_wr && (int'(wr_lv_reg) < MAX_VERTICES)
                    && (int'(wr_rv_reg) < MAX_VERTICES);
        adj_waddr = IW'(wr_lv_reg);
        adj_wdata = adj_row;
        adj_wdata[IW'(wr_rv_reg)] = wr_ep_reg;
    end

    always_comb
    begin
        part_re    = cmd.scan_hit || cmd.emit_rd;
        part_raddr = cmd.scan_hit ? hit_idx : IW'(e_reg);
        part_we    = cmd.take || cmd.aug_wr;
        part_waddr = cmd.take ? hit_v_reg : IW'(stk_next_rd_reg - CW'(1));
        part_wdata = cmd.take ? cur_left_reg : stk_left_rd_reg;

        stk_re    = cmd.pop_rd || cmd.aug_rd;
        stk_raddr = cmd.pop_rd ? IW'(depth_reg - CW'(2)) : IW'(aug_i_reg - CW'(1));
        stk_waddr = IW'(depth_reg - CW'(1));
    end

    always_ff @(posedge clk)
    begin
        if (adj_we)
            adj_mem[adj_waddr] <= adj_wdata;
        if (adj_re)
        begin
            adj_rd_reg  <= adj_mem[adj_raddr];
            adj_rdv_reg <= adj_rv_reg[adj_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (part_we)
            part_mem[part_waddr] <= part_wdata;
        if (part_re)
        begin
            part_rd_reg  <= part_mem[part_raddr];
            part_rdv_reg <= part_v_reg[part_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            stk_left_mem[stk_waddr] <= cur_left_reg;
            stk_next_mem[stk_waddr] <= cur_next_reg;
        end
        if (stk_re)
        begin
            stk_left_rd_reg <= stk_left_mem[stk_raddr];
            stk_next_rd_reg <= stk_next_mem[stk_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_rd)
        begin
            wr_lv_reg <= left_vertex;
            wr_rv_reg <= right_vertex_in;
            wr_ep_reg <= edge_present;
        end
        if (cmd.emit_ld)
        begin
            out_rv_reg   <= VIDX_W'(e_reg);
            out_part_reg <= part_rdv_reg ? VIDX_W'(part_rd_reg) : '0;
            out_pv_reg   <= part_rdv_reg;
            out_cnt_reg  <= CNT_W'(found_reg);
            out_last_reg <= (e_reg == n_reg - CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            adj_rv_reg    <= '0;
            part_v_reg    <= '0;
            n_reg         <= CW'(1);
            u_reg         <= '0;
            depth_reg     <= '0;
            aug_i_reg     <= '0;
            cur_left_reg  <= '0;
            cur_next_reg  <= '0;
            hit_v_reg     <= '0;
            visited_reg   <= '0;
            found_reg     <= '0;
            e_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_adj)
                adj_rv_reg <= '0;
            else if (adj_we)
                adj_rv_reg[adj_waddr] <= 1'b1;

            if (cmd.run_init)
                part_v_reg <= '0;
            else if (part_we)
                part_v_reg[part_waddr] <= 1'b1;

            if (cmd.run_init)
            begin
                n_reg     <= n_next;
                u_reg     <= '0;
                found_reg <= '0;
                e_reg     <= '0;
            end

            if (cmd.try_init)
            begin
                visited_reg  <= '0;
                cur_left_reg <= IW'(u_reg);
                cur_next_reg <= '0;
                depth_reg    <= CW'(1);
            end

            if (cmd.scan_hit)
            begin
                visited_reg[hit_idx] <= 1'b1;
                cur_next_reg         <= CW'(hit_idx) + CW'(1);
                hit_v_reg            <= hit_idx;
            end

            if (cmd.pop_rd)
                depth_reg <= depth_reg - CW'(1);

            if (cmd.pop_ld)
            begin
                cur_left_reg <= stk_left_rd_reg;
                cur_next_reg <= stk_next_rd_reg;
            end

            if (cmd.push)
            begin
                cur_left_reg <= part_rd_reg;
                cur_next_reg <= '0;
                depth_reg    <= depth_reg + CW'(1);
            end

            if (cmd.take)
                aug_i_reg <= depth_reg - CW'(1);
            else if (cmd.aug_wr)
                aug_i_reg <= aug_i_reg - CW'(1);

            if (cmd.try_done)
            begin
                u_reg <= u_reg + CW'(1);
                if (cmd.try_ok)
                    found_reg <= found_reg + CW'(1);
            end

            if (cmd.emit_ld)
            begin
                e_reg         <= e_reg + CW'(1);
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        stat.hit        = |cand;
        stat.depth_one  = (depth_reg == CW'(1));
        stat.depth_full = (depth_reg == CW'(MAX_VERTICES));
        stat.part_valid = part_rdv_reg;
        stat.aug_last   = (aug_i_reg == CW'(1));
        stat.u_last     = (u_reg == n_reg - CW'(1));
        stat.emit_last  = (e_reg == n_reg - CW'(1));
        stat.out_busy   = out_valid_reg && out_stall;
    end

    assign out_valid        = out_valid_reg;
    assign right_vertex_out = out_rv_reg;
    assign partner          = out_part_reg;
    assign partner_valid    = out_pv_reg;
    assign match_count      = out_cnt_reg;
    assign last             = out_last_reg;

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import bmm_pkg::*;

    localparam int NV = 64;
    localparam int IDLE_LIMIT = 400000;

    // The action code that the block leaves unused.
    localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

    typedef struct packed {
        logic [ACT_W-1:0]  act;
        logic [VIDX_W-1:0] lv;
        logic [VIDX_W-1:0] rv;
        logic              ep;
    } request_t;

    typedef struct packed {
        logic [VIDX_W-1:0] rv;
        logic [VIDX_W-1:0] mate;
        logic              mate_ok;
        logic [CNT_W-1:0]  cnt;
        logic              lst;
    } pairing_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [CNT_W-1:0] cfg_wr_data;
    logic in_valid;
    logic in_stall;
    logic [ACT_W-1:0] action;
    logic [VIDX_W-1:0] left_vertex;
    logic [VIDX_W-1:0] right_vertex_in;
    logic edge_present;
    logic out_valid;
    logic out_stall;
    logic [VIDX_W-1:0] right_vertex_out;
    logic [VIDX_W-1:0] partner;
    logic partner_valid;
    logic [CNT_W-1:0] match_count;
    logic last;

    bipartite_max_matching_top i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .left_vertex(left_vertex),
        .right_vertex_in(right_vertex_in), .edge_present(edge_present),
        .out_valid(out_valid), .out_stall(out_stall),
        .right_vertex_out(right_vertex_out), .partner(partner),
        .partner_valid(partner_valid), .match_count(match_count), .last(last)
    );

    // The predictor keeps its own copy of the edge store and the vertex count.
    logic [NV-1:0] edges [NV];
    logic [CNT_W-1:0] vcount_shadow;

    request_t pending_requests[$];
    pairing_t expected_pairings[$];

    int  error_count;
    int  idle_cycles;
    bit  stimulus_done;
    bit  sender_hold;
    bit  timed_out;

    // Matching search state used while predicting a run request.
    logic [NV-1:0] seen;
    logic          mate_ok_of[NV];
    int            mate_of[NV];

    // Recursive depth-first search; scans right vertices from 0 upward, as the
    // block does with its explicit stack, so the same matching is produced.
    function automatic bit try_augment(int x, int n);
        for (int v = 0; v < n; v++) begin
            if (edges[x][v] && !seen[v]) begin
                seen[v] = 1'b1;
                if (!mate_ok_of[v] || try_augment(mate_of[v], n)) begin
                    mate_ok_of[v] = 1'b1;
                    mate_of[v] = x;
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    // Applies one accepted request and queues the pairings it must produce.
    function automatic void predict_matching(request_t r);
        int n;
        int found;
        pairing_t p;
        case (r.act)
            ACT_WRITE: edges[r.lv][r.rv] = r.ep;
            ACT_CLEAR: for (int i = 0; i < NV; i++) edges[i] = '0;
            ACT_RUN: begin
                n = int'(vcount_shadow);
                if (n < 1) n = 1;
                if (n > NV) n = NV;
                found = 0;
                for (int v = 0; v < NV; v++) begin
                    mate_ok_of[v] = 1'b0;
                    mate_of[v] = 0;
                end
                for (int u = 0; u < n; u++) begin
                    seen = '0;
                    if (try_augment(u, n)) found++;
                end
                for (int v = 0; v < n; v++) begin
                    p.rv = v[VIDX_W-1:0];
                    p.mate = mate_ok_of[v] ? mate_of[v][VIDX_W-1:0] : '0;
                    p.mate_ok = mate_ok_of[v];
                    p.cnt = found[CNT_W-1:0];
                    p.lst = (v == n - 1);
                    expected_pairings.insert(expected_pairings.size(), p);
                end
            end
            default: ;  // The unused action code is ignored.
        endcase
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Request driver: bursts of random length separated by random gaps.
    int burst_left;
    int gap_left;
    initial
    begin
        in_valid = 1'b0;
        action = '0;
        left_vertex = '0;
        right_vertex_in = '0;
        edge_present = 1'b0;
        burst_left = 0;
        gap_left = 0;
    end

    always @(negedge clk)
    begin
        if (rst_n && !(in_valid && in_stall)) begin
            // The previous request was taken, or none was offered.
            if (in_valid) void'(pending_requests.pop_front());
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end else if (pending_requests.size() == 0 || sender_hold) begin
                in_valid <= 1'b0;
            end else begin
                in_valid <= 1'b1;
                action <= pending_requests[0].act;
                left_vertex <= pending_requests[0].lv;
                right_vertex_in <= pending_requests[0].rv;
                edge_present <= pending_requests[0].ep;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(12, 1);
                    gap_left <= ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(6, 1);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // Receiver stall pattern: switches between calm stretches, light stalling and heavy stalling.
    int stall_mode;
    initial
    begin
        out_stall = 1'b0;
        stall_mode = 0;
    end

    always @(negedge clk)
    begin
        if ($urandom_range(63, 0) == 0) stall_mode <= $urandom_range(2, 0);
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(3, 0) == 0);
            default: out_stall <= ($urandom_range(3, 0) != 0);
        endcase
    end

    // Monitor: predicts on accepted requests and checks accepted results.
    always @(posedge clk)
    begin
        pairing_t want;
        if (rst_n) begin
            if (in_valid && !in_stall) predict_matching(pending_requests[0]);
            if (out_valid && !out_stall) begin
                if (expected_pairings.size() == 0) begin
                    $display("%0t: result expected none actual rv=%0d partner=%0d", $time,
                             right_vertex_out, partner);
                    error_count++;
                end else begin
                    want = expected_pairings.pop_front();
                    if (right_vertex_out !== want.rv) begin
                        $display("%0t: right_vertex_out expected %0d actual %0d",
                                 $time, want.rv, right_vertex_out);
                        error_count++;
                    end
                    if (partner !== want.mate) begin
                        $display("%0t: partner expected %0d actual %0d",
                                 $time, want.mate, partner);
                        error_count++;
                    end
                    if (partner_valid !== want.mate_ok) begin
                        $display("%0t: partner_valid expected %0d actual %0d",
                                 $time, want.mate_ok, partner_valid);
                        error_count++;
                    end
                    if (match_count !== want.cnt) begin
                        $display("%0t: match_count expected %0d actual %0d",
                                 $time, want.cnt, match_count);
                        error_count++;
                    end
                    if (last !== want.lst) begin
                        $display("%0t: last expected %0d actual %0d",
                                 $time, want.lst, last);
                        error_count++;
                    end
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
        end
    end

    // Request builders used by the stimulus.
    function automatic void queue_edge(int l, int r, bit present);
        request_t q;
        q.act = ACT_WRITE;
        q.lv = l[VIDX_W-1:0];
        q.rv = r[VIDX_W-1:0];
        q.ep = present;
        pending_requests.insert(pending_requests.size(), q);
    endfunction

    function automatic void queue_command(logic [ACT_W-1:0] a);
        request_t q;
        q.act = a;
        q.lv = VIDX_W'($urandom());
        q.rv = VIDX_W'($urandom());
        q.ep = 1'($urandom());
        pending_requests.insert(pending_requests.size(), q);
    endfunction

    // Waits until everything queued has been taken and every result has come,
    // then lets the block finish any trailing write or clear.
    task automatic drain();
        while (pending_requests.size() != 0 || in_valid || expected_pairings.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_vertex_count(int n);
        drain();
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= n[CNT_W-1:0];
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        vcount_shadow = n[CNT_W-1:0];
    endtask

    // A random graph of the given size, with random commands and out-of-range writes mixed in.
    task automatic random_graph_phase(int n, int writes);
        set_vertex_count(n);
        queue_command(ACT_CLEAR);
        for (int i = 0; i < writes; i++) begin
            if ($urandom_range(15, 0) == 0)
                queue_command(ACT_W'($urandom_range(3, 0)));
            else if ($urandom_range(9, 0) == 0)
                queue_edge($urandom_range(63, 0), $urandom_range(63, 0), 1'($urandom()));
            else
                queue_edge($urandom_range(n - 1, 0), $urandom_range(n - 1, 0),
                           $urandom_range(3, 0) != 0);
        end
        queue_command(ACT_RUN);
    endtask

    initial
    begin
        int sizes[$];
        error_count = 0;
        idle_cycles = 0;
        stimulus_done = 0;
        sender_hold = 0;
        timed_out = 0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        vcount_shadow = 1;
        for (int i = 0; i < NV; i++) edges[i] = '0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: the reset vertex count, the extremes of both indices,
        // an augmenting path that must reroute, and the unused action code.
        queue_command(ACT_RUN);
        queue_edge(0, 0, 1'b1);
        queue_command(ACT_RUN);
        queue_command(ACT_SPARE);
        set_vertex_count(0);
        queue_command(ACT_RUN);
        set_vertex_count(3);
        queue_edge(0, 0, 1'b1);
        queue_edge(0, 1, 1'b1);
        queue_edge(1, 0, 1'b1);
        queue_edge(2, 1, 1'b1);
        queue_edge(63, 63, 1'b1);
        queue_command(ACT_RUN);
        queue_edge(0, 1, 1'b0);
        queue_command(ACT_RUN);
        set_vertex_count(64);
        queue_edge(63, 63, 1'b1);
        queue_edge(63, 0, 1'b1);
        queue_command(ACT_RUN);
        queue_command(ACT_CLEAR);
        queue_command(ACT_RUN);
        set_vertex_count(127);
        for (int i = 0; i < 4; i++) queue_edge(i, 63 - i, 1'b1);
        queue_command(ACT_RUN);

        // Hold the sender until the block has caught up completely.
        drain();
        sender_hold = 1;
        repeat (20) @(posedge clk);
        sender_hold = 0;

        // Random part: small graphs, with a couple of full-size ones.
        sizes = '{2, 5, 8, 3, 64, 6, 1, 4, 7, 64};
        foreach (sizes[k])
            random_graph_phase(sizes[k], (sizes[k] == 64) ? 16 : 8);
        drain();
        stimulus_done = 1;
    end

    // End of run: pass or fail once everything has drained, or on a stuck run.
    initial
    begin
        wait (rst_n);
        while (!stimulus_done && !timed_out) begin
            @(posedge clk);
            if (idle_cycles > IDLE_LIMIT) timed_out = 1;
        end
        if (timed_out) begin
            $display("tb_top NOT OK");
            $finish;
        end else begin
            repeat (50) @(posedge clk);
            if (error_count == 0 && expected_pairings.size() == 0) $display("tb_top OK");
            else $display("tb_top NOT OK");
            $finish;
        end
    end

endmodule

// File: sim.f
rtl/bmm_pkg.sv
rtl/bmm_ctrl.sv
rtl/bmm_datapath.sv
rtl/bipartite_max_matching_top.sv
sim/tb_top.sv
